### src/gcmd_pkg.sv
// ----------------------------------------------------------------------------
// gcmd_pkg : shared types, constants and the gamma decode table builder
// Payload structs for the pixel and mip channels, register indexes, encoder
// states, and an elaboration-time builder for the gamma-2.2 decode table.
// ----------------------------------------------------------------------------
package gcmd_pkg;

   // Register port
   localparam int CsrIndexBits  = 1;
   localparam int CsrDataBits   = 15;
   localparam int WidthRegBits  = 11;
   localparam int HeightRegBits = 15;

   localparam logic [CsrIndexBits-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CsrIndexBits-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   // Height limits and row counter
   localparam int RowBits     = 14;
   localparam int HeightLimit = 16384;

   // Decoupling queue between front and encoder
   localparam int FifoDepth = 4;

   // Decode table storage: entries are held at the widest linear format
   localparam int LinMaxBits = 24;
   localparam int BigBits    = 256;

   typedef logic [255:0][LinMaxBits-1:0] lin_table_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       mip_end;
   } rsp_type;

   typedef enum logic [1:0] {
      ENC_IDLE,
      ENC_SEARCH,
      ENC_HOLD
   } enc_state_type;

   // decode(v) = largest L in [0, M] with L^5 * 255^11 <= v^11 * M^5,
   // M = 2^lb - 1. Exact integer binary search, evaluated at elaboration.
   function automatic lin_table_type build_decode_table(input int lb);
      lin_table_type         tbl;
      logic [BigBits-1:0]    k255;
      logic [BigBits-1:0]    rhs;
      logic [BigBits-1:0]    lhs;
      logic [LinMaxBits:0]   full;
      logic [LinMaxBits:0]   lo;
      logic [LinMaxBits:0]   hi;
      logic [LinMaxBits:0]   mid;
      full = (LinMaxBits + 1)'((33'd1 << lb) - 33'd1);
      k255 = BigBits'(1);
      for (int i = 0; i < 11; i++) begin
         k255 = k255 * BigBits'(255);
      end
      for (int v = 0; v < 256; v++) begin
         rhs = BigBits'(1);
         for (int i = 0; i < 11; i++) begin
            rhs = rhs * BigBits'(v);
         end
         for (int i = 0; i < 5; i++) begin
            rhs = rhs * BigBits'(full);
         end
         lo = '0;
         hi = full;
         for (int s = 0; s <= LinMaxBits; s++) begin
            if (lo < hi) begin
               mid = lo + ((hi - lo + (LinMaxBits + 1)'(1)) >> 1);
               lhs = k255;
               for (int i = 0; i < 5; i++) begin
                  lhs = lhs * BigBits'(mid);
               end
               if (lhs <= rhs) begin
                  lo = mid;
               end else begin
                  hi = mid - (LinMaxBits + 1)'(1);
               end
            end
         end
         tbl[v] = lo[LinMaxBits-1:0];
      end
      return tbl;
   endfunction

endpackage

### src/gcmd_fifo.sv
// ----------------------------------------------------------------------------
// gcmd_fifo : short decoupling queue
// Holds averaged blocks between the front and the encoder so either side can
// stall on its own.
// ----------------------------------------------------------------------------
module gcmd_fifo #(
   parameter int Width = 65,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] rdata,
   output logic             empty
);

   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntBits = $clog2(Depth + 1);

   logic [Width-1:0]   entry_ff [Depth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CntBits'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### src/gcmd_front.sv
// ----------------------------------------------------------------------------
// gcmd_front : pixel intake, gamma decode and 2x2 accumulation
// Tracks the raster position, decodes each channel to linear, keeps the
// even-row pair sums in a line memory and pushes block averages to the queue.
// ----------------------------------------------------------------------------
module gcmd_front import gcmd_pkg::*; #(
   parameter int MAX_WIDTH   = 1024,
   parameter int LINEAR_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  req_type                  req_data,
   input  logic                     csr_we,
   input  logic [CsrIndexBits-1:0]  csr_index,
   input  logic [CsrDataBits-1:0]   csr_wdata,
   output logic                     fifo_push,
   output logic [4*LINEAR_BITS:0]   fifo_wdata,
   input  logic                     fifo_full
);

   localparam int ColBits    = $clog2(MAX_WIDTH);
   localparam int WidthBits  = $clog2(MAX_WIDTH + 1);
   localparam int PairSlots  = (MAX_WIDTH + 1) / 2;
   localparam int SlotBits   = (PairSlots > 1) ? $clog2(PairSlots) : 1;
   localparam int PairBits   = LINEAR_BITS + 1;
   localparam int MemWidth   = 4 * PairBits;
   localparam int ResetWidth = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam logic [ColBits-1:0] ResetWidthLast = ColBits'(ResetWidth - 1);
   localparam logic [ColBits-1:0] ResetColEnd    = ColBits'((ResetWidth / 2) * 2 - 1);
   localparam lin_table_type DecodeTable = build_decode_table(LINEAR_BITS);

   logic [7:0]             chan [4];
   logic [LINEAR_BITS-1:0] lin [4];
   logic [MemWidth-1:0]    pair_row;
   logic                   accept, odd_col, odd_row, is_last, cfg_restart;
   logic [SlotBits-1:0]    slot;

   // raster position and held even-column pixel
   logic [ColBits-1:0]     col_ff, col_in;
   logic [RowBits-1:0]     row_ff, row_in;
   logic [LINEAR_BITS-1:0] held_ff [4];
   logic [LINEAR_BITS-1:0] held_in [4];

   // image geometry
   logic [ColBits-1:0]     width_last_ff, width_last_in;
   logic [ColBits-1:0]     col_end_ff, col_end_in;
   logic [RowBits-1:0]     height_last_ff, height_last_in;
   logic [RowBits-1:0]     row_end_ff, row_end_in;
   logic [WidthRegBits-1:0]  wr_width;
   logic [WidthBits-1:0]     eff_width;
   logic [HeightRegBits-1:0] wr_height;
   logic [HeightRegBits-1:0] eff_height;

   // second stage: memory read data and the lower-row pair
   logic                   stg_vld_ff, stg_vld_in;
   logic                   stg_last_ff;
   logic [MemWidth-1:0]    stg_pair_ff;
   logic [MemWidth-1:0]    upper_ff;
   logic [MemWidth-1:0]    pair_mem [PairSlots];

   logic [PairBits:0]      block_sum [4];
   logic [LINEAR_BITS-1:0] block_avg [4];

   assign chan[0] = req_data.in_red;
   assign chan[1] = req_data.in_green;
   assign chan[2] = req_data.in_blue;
   assign chan[3] = req_data.in_alpha;

   assign req_full    = stg_vld_ff && fifo_full;
   assign accept      = req_push && !req_full;
   assign odd_col     = col_ff[0];
   assign odd_row     = row_ff[0];
   assign slot        = SlotBits'(col_ff >> 1);
   assign is_last     = (row_ff == row_end_ff) && (col_ff == col_end_ff);
   assign cfg_restart = csr_we &&
                        (csr_index == CSR_SOURCE_WIDTH || csr_index == CSR_SOURCE_HEIGHT);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         lin[c] = DecodeTable[chan[c]][LINEAR_BITS-1:0];
         pair_row[c*PairBits +: PairBits] = {1'b0, held_ff[c]} + {1'b0, lin[c]};
      end
   end

   // saturate the written geometry
   always_comb begin
      wr_width  = csr_wdata[WidthRegBits-1:0];
      wr_height = csr_wdata[HeightRegBits-1:0];
      if (wr_width < WidthRegBits'(2)) begin
         eff_width = WidthBits'(2);
      end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
         eff_width = WidthBits'(MAX_WIDTH);
      end else begin
         eff_width = WidthBits'(wr_width);
      end
      if (wr_height < HeightRegBits'(2)) begin
         eff_height = HeightRegBits'(2);
      end else if (wr_height > HeightRegBits'(HeightLimit)) begin
         eff_height = HeightRegBits'(HeightLimit);
      end else begin
         eff_height = wr_height;
      end
   end

   always_comb begin
      width_last_in  = width_last_ff;
      col_end_in     = col_end_ff;
      height_last_in = height_last_ff;
      row_end_in     = row_end_ff;
      if (csr_we && csr_index == CSR_SOURCE_WIDTH) begin
         width_last_in = ColBits'(eff_width - WidthBits'(1));
         col_end_in    = ColBits'({eff_width[WidthBits-1:1], 1'b0} - WidthBits'(1));
      end
      if (csr_we && csr_index == CSR_SOURCE_HEIGHT) begin
         height_last_in = RowBits'(eff_height - HeightRegBits'(1));
         row_end_in     = RowBits'({eff_height[HeightRegBits-1:1], 1'b0} - HeightRegBits'(1));
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (cfg_restart) begin
         col_in  = '0;
         row_in  = '0;
         held_in = '{default: '0};
      end else if (accept) begin
         if (!odd_col) begin
            held_in = lin;
         end
         if (col_ff == width_last_ff) begin
            col_in = '0;
            row_in = (row_ff == height_last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign fifo_push  = stg_vld_ff && !fifo_full;
   assign stg_vld_in = (stg_vld_ff && fifo_full) || (accept && odd_col && odd_row);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         block_sum[c] = {1'b0, upper_ff[c*PairBits +: PairBits]}
                      + {1'b0, stg_pair_ff[c*PairBits +: PairBits]};
         block_avg[c] = block_sum[c][PairBits:2];
      end
      fifo_wdata = {stg_last_ff, block_avg[3], block_avg[2], block_avg[1], block_avg[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         held_ff        <= '{default: '0};
         width_last_ff  <= ResetWidthLast;
         col_end_ff     <= ResetColEnd;
         height_last_ff <= RowBits'(255);
         row_end_ff     <= RowBits'(255);
         stg_vld_ff     <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         held_ff        <= held_in;
         width_last_ff  <= width_last_in;
         col_end_ff     <= col_end_in;
         height_last_ff <= height_last_in;
         row_end_ff     <= row_end_in;
         stg_vld_ff     <= stg_vld_in;
      end
   end

   // line memory: even rows write the pair sums, odd rows read them back
   always_ff @(posedge clock) begin
      if (accept && odd_col && !odd_row) begin
         pair_mem[slot] <= pair_row;
      end
      if (accept && odd_col && odd_row) begin
         upper_ff    <= pair_mem[slot];
         stg_pair_ff <= pair_row;
         stg_last_ff <= is_last;
      end
   end

endmodule

### src/gcmd_encode.sv
// ----------------------------------------------------------------------------
// gcmd_encode : linear-to-byte re-encoder
// Bit-by-bit search of the decode table, one bit per cycle on all four
// channels, then the result moves into the output register.
// ----------------------------------------------------------------------------
module gcmd_encode import gcmd_pkg::*; #(
   parameter int LINEAR_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fifo_empty,
   input  logic [4*LINEAR_BITS:0] fifo_rdata,
   output logic                   fifo_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data
);

   localparam lin_table_type DecodeTable = build_decode_table(LINEAR_BITS);

   enc_state_type          state_ff, state_in;
   logic [LINEAR_BITS-1:0] avg_ff [4];
   logic [7:0]             code_ff [4];
   logic [7:0]             trial [4];
   logic [2:0]             bit_ff;
   logic                   last_ff;
   logic                   rsp_vld_ff, rsp_vld_in;
   rsp_type                rsp_data_ff;
   logic                   out_free, load_out, searching;

   assign out_free   = !rsp_vld_ff || rsp_pop;
   assign rsp_empty  = !rsp_vld_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_vld_in = load_out || (rsp_vld_ff && !rsp_pop);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         trial[c] = code_ff[c] | (8'd1 << bit_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENC_IDLE: begin
            if (!fifo_empty) begin
               state_in = ENC_SEARCH;
            end
         end
         ENC_SEARCH: begin
            if (bit_ff == 3'd0) begin
               state_in = ENC_HOLD;
            end
         end
         ENC_HOLD: begin
            if (out_free) begin
               state_in = ENC_IDLE;
            end
         end
         default: state_in = ENC_IDLE;
      endcase
   end

   always_comb begin
      fifo_pop  = 1'b0;
      load_out  = 1'b0;
      searching = 1'b0;
      unique case (state_ff)
         ENC_IDLE:   fifo_pop  = !fifo_empty;
         ENC_SEARCH: searching = 1'b1;
         ENC_HOLD:   load_out  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ENC_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         for (int c = 0; c < 4; c++) begin
            avg_ff[c]  <= fifo_rdata[c*LINEAR_BITS +: LINEAR_BITS];
            code_ff[c] <= 8'd0;
         end
         last_ff <= fifo_rdata[4*LINEAR_BITS];
         bit_ff  <= 3'd7;
      end else if (searching) begin
         for (int c = 0; c < 4; c++) begin
            if (DecodeTable[trial[c]][LINEAR_BITS-1:0] <= avg_ff[c]) begin
               code_ff[c] <= trial[c];
            end
         end
         bit_ff <= bit_ff - 3'd1;
      end
      if (load_out) begin
         rsp_data_ff.out_red   <= code_ff[0];
         rsp_data_ff.out_green <= code_ff[1];
         rsp_data_ff.out_blue  <= code_ff[2];
         rsp_data_ff.out_alpha <= code_ff[3];
         rsp_data_ff.mip_end   <= last_ff;
      end
   end

endmodule

### src/gamma_correct_mip_downsample.sv
// ----------------------------------------------------------------------------
// gamma_correct_mip_downsample : gamma-correct 2x2 box mip downsampler
// Decodes RGBA8 pixels through a gamma-2.2 table to linear fixed point,
// averages each 2x2 block and re-encodes the average to bytes.
// ----------------------------------------------------------------------------
//
//  channel   ports                               one transaction
//  --------  ----------------------------------  ------------------------------
//  pixel in  req_push, req_full, req_data        one source pixel, raster order
//  mip out   rsp_empty, rsp_pop, rsp_data        one mip pixel, mip_end on last
//  csr       csr_we, csr_index, csr_wdata        0: source_width 1: source_height
//
//  Pixels are taken one per cycle while the front is not stalled; even rows
//  only fill the line memory. Each mip pixel passes through the encoder's
//  queue pop, 8 table-search steps and output load, and the encoder takes
//  no new average until the last one is loaded into the output register.
//  A block average passes through the stage register and the queue first.
//  Synchronous active-high reset; geometry resets to 256 x 256.
//  req_full rises only when the queue is full and a block average is waiting.
//
module gamma_correct_mip_downsample import gcmd_pkg::*; #(
   parameter int MAX_WIDTH   = 1024,
   parameter int LINEAR_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  req_type                 req_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata
);

   localparam int QueueWidth = 4 * LINEAR_BITS + 1;

   // front -> queue
   logic                  fifo_push;
   logic                  fifo_full;
   logic [QueueWidth-1:0] fifo_wdata;

   // queue -> encoder
   logic                  fifo_pop;
   logic                  fifo_empty;
   logic [QueueWidth-1:0] fifo_rdata;

   // Front: position tracking, decode, line memory, block averages
   gcmd_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .LINEAR_BITS (LINEAR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fifo_push  (fifo_push),
      .fifo_wdata (fifo_wdata),
      .fifo_full  (fifo_full)
   );

   // Short queue of averages so the encoder search does not stall intake until it fills
   gcmd_fifo #(
      .Width (QueueWidth),
      .Depth (FifoDepth)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fifo_push),
      .wdata (fifo_wdata),
      .full  (fifo_full),
      .pop   (fifo_pop),
      .rdata (fifo_rdata),
      .empty (fifo_empty)
   );

   // Back: byte re-encode and output register
   gcmd_encode #(
      .LINEAR_BITS (LINEAR_BITS)
   ) u_encode (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_rdata (fifo_rdata),
      .fifo_pop   (fifo_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

### src/gcmd_checker.sv
// ----------------------------------------------------------------------------
// gcmd_checker : port-level checks for the mip downsampler
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module gcmd_checker import gcmd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // Out of reset nothing is queued and intake is open
   a_reset_clean: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("queue not clear after reset");

   // A waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("pending result changed or vanished");

   // Pipeline depth: no result can surface straight out of reset
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
      else $error("result appeared too soon after reset");

   // Intake is not stalled straight out of reset, before any average can back up
   a_full_needs_work: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !$past(reset, 1))
      else $error("full asserted straight out of reset");

endmodule

bind gamma_correct_mip_downsample gcmd_checker u_gcmd_checker (.*);
